@@ src/zdle_pkg.sv @@
// zdle_pkg: shared types and constants for the ZDLE escape decoder.
// No dependencies; used by every module of the decoder.

package zdle_pkg;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_END     = 3'd1,
        KIND_CANCEL  = 3'd2,
        KIND_BADESC  = 3'd3,
        KIND_TIMEOUT = 3'd4
    } kind_t;

    // Register addresses (byte addresses)
    localparam int unsigned ADDR_WIDTH = 2;
    localparam logic [ADDR_WIDTH-1:0] REG_ESCAPE_CONTROLS = 2'd0;

    localparam logic [7:0] ZDLE_BYTE = 8'h18;
    localparam logic [7:0] CAN_BYTE  = 8'h18;
    localparam logic [7:0] XON_BYTE  = 8'h11;
    localparam logic [7:0] XOFF_BYTE = 8'h13;
    localparam logic [7:0] XON_PAR   = 8'h91;
    localparam logic [7:0] XOFF_PAR  = 8'h93;
    localparam logic [7:0] END_CRCE  = 8'h68;
    localparam logic [7:0] END_CRCW  = 8'h6B;
    localparam logic [7:0] RUB0_BYTE = 8'h6C;
    localparam logic [7:0] RUB1_BYTE = 8'h6D;
    localparam logic [7:0] RUB0_DATA = 8'h7F;
    localparam logic [7:0] RUB1_DATA = 8'hFF;
    localparam logic [7:0] CASE_FLIP = 8'h40;

    // Outcome of decoding one request
    typedef struct packed {
        logic       emit;
        kind_t      kind;
        logic [7:0] value;
    } dec_result_t;

endpackage

@@ src/zdle_cfg_regs.sv @@
// zdle_cfg_regs: APB-style configuration register file of the decoder.
// Depends on zdle_pkg.

module zdle_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [zdle_pkg::ADDR_WIDTH-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic                              escape_controls
);

    logic escape_controls_reg;
    logic escape_controls_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Only one register exists, so every address in the window selects it.
    always_comb begin
        escape_controls_next = escape_controls_reg;
        if (wr_en) begin
            escape_controls_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_controls_reg <= 1'b0;
        end else begin
            escape_controls_reg <= escape_controls_next;
        end
    end

    always_comb begin
        prdata = 32'd0;
        case (paddr)
            zdle_pkg::REG_ESCAPE_CONTROLS: prdata = {31'd0, escape_controls_reg};
            default:                       prdata = {31'd0, escape_controls_reg};
        endcase
    end

    assign escape_controls = escape_controls_reg;

endmodule

@@ src/zdle_decode.sv @@
// zdle_decode: escape state registers and the single-pass decode logic.
// Depends on zdle_pkg.

module zdle_decode (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic [7:0]            line_byte,
    input  logic                  timed_out,
    input  logic                  escape_controls,
    output zdle_pkg::dec_result_t result
);

    logic       escape_pending_reg;
    logic       escape_pending_next;
    logic [1:0] cancel_run_reg;
    logic [1:0] cancel_run_next;
    logic       is_flow;
    logic       is_ctrl;

    assign is_flow = (line_byte == zdle_pkg::XON_BYTE) || (line_byte == zdle_pkg::XOFF_BYTE) ||
                     (line_byte == zdle_pkg::XON_PAR)  || (line_byte == zdle_pkg::XOFF_PAR);
    assign is_ctrl = (line_byte[6:5] == 2'b00);

    always_comb begin
        escape_pending_next = escape_pending_reg;
        cancel_run_next     = cancel_run_reg;
        result.emit         = 1'b0;
        result.kind         = zdle_pkg::KIND_DATA;
        result.value        = 8'd0;

        if (timed_out) begin
            escape_pending_next = 1'b0;
            cancel_run_next     = 2'd0;
            result.emit         = 1'b1;
            result.kind         = zdle_pkg::KIND_TIMEOUT;
        end else if (!escape_pending_reg) begin
            if (line_byte == zdle_pkg::ZDLE_BYTE) begin
                escape_pending_next = 1'b1;
                cancel_run_next     = 2'd0;
            end else if (!is_flow && !(escape_controls && is_ctrl)) begin
                result.emit  = 1'b1;
                result.value = line_byte;
            end
        end else if (line_byte == zdle_pkg::CAN_BYTE) begin
            if (cancel_run_reg == 2'd3) begin
                escape_pending_next = 1'b0;
                cancel_run_next     = 2'd0;
                result.emit         = 1'b1;
                result.kind         = zdle_pkg::KIND_CANCEL;
            end else begin
                cancel_run_next = cancel_run_reg + 2'd1;
            end
        end else if (is_flow || (escape_controls && is_ctrl)) begin
            // Dropped inside an escape: the escape stays open.
            cancel_run_next = 2'd0;
        end else begin
            escape_pending_next = 1'b0;
            cancel_run_next     = 2'd0;
            result.emit         = 1'b1;
            if (line_byte >= zdle_pkg::END_CRCE && line_byte <= zdle_pkg::END_CRCW) begin
                result.kind  = zdle_pkg::KIND_END;
                result.value = {6'd0, line_byte[1:0]};
            end else if (line_byte == zdle_pkg::RUB0_BYTE) begin
                result.value = zdle_pkg::RUB0_DATA;
            end else if (line_byte == zdle_pkg::RUB1_BYTE) begin
                result.value = zdle_pkg::RUB1_DATA;
            end else if (line_byte[6:5] == 2'b10) begin
                result.value = line_byte ^ zdle_pkg::CASE_FLIP;
            end else begin
                result.kind = zdle_pkg::KIND_BADESC;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_pending_reg <= 1'b0;
            cancel_run_reg     <= 2'd0;
        end else if (advance) begin
            escape_pending_reg <= escape_pending_next;
            cancel_run_reg     <= cancel_run_next;
        end
    end

endmodule

@@ src/zdle_escape_decoder_unit.sv @@
// Each request is registered in the input register, its result in the result register that
// drives m_valid; a request whose result finds the result register full and stalled waits in
// the input register. Throughput: one request per cycle unless a result stalls, with no gap
// after requests that give no result; decode is one logic pass between the two registers.
// Reset: aresetn is synchronous and active low; it clears both registers' valid flags,
// the escape state and escape_controls.

module zdle_escape_decoder_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_line_byte,
    input  logic                              s_timed_out,
    // Result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_kind,
    output logic [7:0]                        m_value,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [zdle_pkg::ADDR_WIDTH-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    // Input register: holds the request that is being decoded in this cycle.
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [7:0]            in_byte_reg;
    logic                  in_timed_out_reg;

    // Result register: holds a finished result until the consumer takes it.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    zdle_pkg::kind_t       out_kind_reg;
    logic [7:0]            out_value_reg;

    logic                  escape_controls;
    logic                  advance;
    logic                  s_accept;
    zdle_pkg::dec_result_t result;

    zdle_cfg_regs u_cfg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .escape_controls (escape_controls)
    );

    zdle_decode u_decode (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .line_byte       (in_byte_reg),
        .timed_out       (in_timed_out_reg),
        .escape_controls (escape_controls),
        .result          (result)
    );

    // The held request leaves the input register when it gives no result, or when the
    // result register is empty or being emptied in the same cycle. The escape state is
    // committed only at that point, so a stalled request is decoded again unchanged.
    assign advance  = in_valid_reg && (!result.emit || !out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && result.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg      <= s_line_byte;
            in_timed_out_reg <= s_timed_out;
        end
        if (advance && result.emit) begin
            out_kind_reg  <= result.kind;
            out_value_reg <= result.value;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_kind  = out_kind_reg;
    assign m_value = out_value_reg;

endmodule

@@ src/zdle_checker.sv @@
// zdle_checker: port-level assertions for the ZDLE escape decoder, bound to the top level.
// Depends on zdle_pkg and zdle_escape_decoder_unit.

module zdle_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_kind,
    input logic [7:0] m_value
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_value))
        else $error("result changed while stalled");

    // No result is shown in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    // A frame end names one of four ends only.
    a_end_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == zdle_pkg::KIND_END) |-> (m_value[7:2] == 6'd0))
        else $error("frame end out of range");

    // Cancel, bad escape and timeout carry a zero value.
    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_kind == zdle_pkg::KIND_CANCEL) || (m_kind == zdle_pkg::KIND_BADESC) ||
                    (m_kind == zdle_pkg::KIND_TIMEOUT)) |-> (m_value == 8'd0))
        else $error("non-data result with a value");

endmodule

bind zdle_escape_decoder_unit zdle_checker u_zdle_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_kind  (m_kind),
    .m_value (m_value)
);
